FILE: rtl/pqe_pkg.sv
`timescale 1ns / 1ps
package pqe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int XW        = 31;
    localparam int PW        = 31;
    localparam int EW        = 30;
    localparam int ZW        = 35;
    localparam int NUMW      = 33;
    localparam int REMW      = NUMW + 1;
    localparam int QW        = 31;

    localparam int LOG_LAT   = FRAC_BITS;
    localparam int EXP_LAT   = FRAC_BITS + 1;
    localparam int DIV_LAT   = QW;
    localparam int CH_LAT    = 6 + 2 * LOG_LAT + 2 * EXP_LAT + DIV_LAT;

    localparam int EXP_CUT   = 62;

    localparam logic [35:0] NUM_BASE = 36'd3424 << 18;
    localparam logic [35:0] DEN_BASE = 36'd1 << 30;

    typedef enum logic [1:0] {
        SP_NONE,
        SP_ZERO,
        SP_SAT
    } sp_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bm;
        v   = val;
        res = '0;
        bm  = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= res + bm)
            begin
                v   = v - (res + bm);
                res = (res >> 1) + bm;
            end
            else
            begin
                res = res >> 1;
            end
            bm = bm >> 2;
        end
        return res;
    endfunction

    // floor(2^60 / 2^(2^-idx) in Q30), long division at elaboration
    function automatic logic [EW-1:0] pow_entry(input int idx);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] q;
        root = 64'd1 << 31;
        for (int k = 1; k <= FRAC_BITS; k++)
        begin
            if (k <= idx)
            begin
                root = isqrt64(root << 30);
            end
        end
        rem = '0;
        q   = '0;
        for (int k = 60; k >= 0; k--)
        begin
            rem = {rem[62:0], (k == 60)};
            if (rem >= root)
            begin
                rem  = rem - root;
                q[k] = 1'b1;
            end
        end
        return q[EW-1:0];
    endfunction

endpackage

FILE: rtl/pqe_log2.sv
`timescale 1ns / 1ps
module pqe_log2 (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pqe_pkg::XW-1:0]        x_in,
    output logic [pqe_pkg::FRAC_BITS-1:0] frac_out
);
    import pqe_pkg::*;

    logic [XW-1:0]        x_reg [LOG_LAT];
    logic [FRAC_BITS-1:0] r_reg [LOG_LAT];

    for (genvar k = 0; k < LOG_LAT; k++)
    begin : g_stage
        logic [XW-1:0]        x_cur;
        logic [FRAC_BITS-1:0] r_cur;
        logic [2*XW-1:0]      sq;
        logic [XW:0]          s;
        logic [XW-1:0]        x_next;
        logic [FRAC_BITS-1:0] r_next;

        if (k == 0)
        begin : g_first
            assign x_cur = x_in;
            assign r_cur = '0;
        end
        else
        begin : g_rest
            assign x_cur = x_reg[k-1];
            assign r_cur = r_reg[k-1];
        end

        assign sq = x_cur * x_cur;
        assign s  = sq[2*XW-1:XW-1];

        always_comb
        begin
            x_next = s[XW] ? s[XW:1] : s[XW-1:0];
            r_next = r_cur;
            r_next[FRAC_BITS-1-k] = s[XW];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign frac_out = r_reg[LOG_LAT-1];

endmodule

FILE: rtl/pqe_exp2.sv
`timescale 1ns / 1ps
module pqe_exp2 (
    input  logic                   clk,
    input  logic                   en,
    input  logic [pqe_pkg::ZW-1:0] z_in,
    output logic [pqe_pkg::PW-1:0] p_out
);
    import pqe_pkg::*;

    localparam logic [PW-1:0] P_ONE = PW'(1) << 30;

    logic [PW-1:0] p_reg [FRAC_BITS];
    logic [ZW-1:0] z_reg [FRAC_BITS];
    logic [PW-1:0] out_reg;
    logic [ZW-FRAC_BITS-1:0] n;

    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_stage
        localparam logic [EW-1:0] E = pow_entry(k + 1);
        logic [PW-1:0]    p_cur;
        logic [ZW-1:0]    z_cur;
        logic [PW+EW-1:0] prod;
        logic [PW-1:0]    p_next;

        if (k == 0)
        begin : g_first
            assign p_cur = P_ONE;
            assign z_cur = z_in;
        end
        else
        begin : g_rest
            assign p_cur = p_reg[k-1];
            assign z_cur = z_reg[k-1];
        end

        assign prod   = p_cur * E;
        assign p_next = z_cur[FRAC_BITS-1-k] ? prod[PW+EW-1:30] : p_cur;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k] <= p_next;
                z_reg[k] <= z_cur;
            end
        end
    end

    assign n = z_reg[FRAC_BITS-1][ZW-1:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (n >= (ZW-FRAC_BITS)'(EXP_CUT))
            begin
                out_reg <= '0;
            end
            else
            begin
                out_reg <= p_reg[FRAC_BITS-1] >> n;
            end
        end
    end

    assign p_out = out_reg;

endmodule

FILE: rtl/pqe_div.sv
`timescale 1ns / 1ps
module pqe_div (
    input  logic                     clk,
    input  logic                     en,
    input  logic [pqe_pkg::NUMW-1:0] num_in,
    input  logic [pqe_pkg::NUMW-1:0] den_in,
    output logic [pqe_pkg::QW-1:0]   q_out
);
    import pqe_pkg::*;

    logic [REMW-1:0] rem_reg [DIV_LAT];
    logic [NUMW-1:0] den_reg [DIV_LAT];
    logic [QW-1:0]   q_reg   [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_stage
        logic [REMW-1:0] rem_cur;
        logic [NUMW-1:0] den_cur;
        logic [QW-1:0]   q_cur;
        logic            ge;
        logic [REMW-1:0] diff;
        logic [REMW-1:0] rsel;
        logic [REMW-1:0] rem_next;
        logic [QW-1:0]   q_next;

        if (k == 0)
        begin : g_first
            assign rem_cur = {1'b0, num_in};
            assign den_cur = den_in;
            assign q_cur   = '0;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign q_cur   = q_reg[k-1];
        end

        assign ge       = rem_cur >= {1'b0, den_cur};
        assign diff     = rem_cur - {1'b0, den_cur};
        assign rsel     = ge ? diff : rem_cur;
        assign rem_next = {rsel[REMW-2:0], 1'b0};

        always_comb
        begin
            q_next = q_cur;
            q_next[QW-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_cur;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign q_out = q_reg[DIV_LAT-1];

endmodule

FILE: rtl/pqe_channel.sv
`timescale 1ns / 1ps
module pqe_channel (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] half_in,
    output logic [7:0]  code
);
    import pqe_pkg::*;

    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] msb;
    sp_t        sp_d;
    logic [4:0] neg_d;
    logic [9:0] frac_d;

    sp_t             sp_pipe_reg  [CH_LAT-1];
    logic [4:0]      neg_pipe_reg [LOG_LAT+1];
    logic [XW-1:0]   xa_reg;
    logic [FRAC_BITS-1:0] la;
    logic [32:0]     t;
    logic [44:0]     yprod;
    logic [30:0]     y_reg;
    logic [PW-1:0]   lm;
    logic [42:0]     nprod;
    logic [42:0]     dprod;
    logic [35:0]     num_sum;
    logic [35:0]     den_sum;
    logic [NUMW-1:0] num_reg;
    logic [NUMW-1:0] den_reg;
    logic [QW-1:0]   r;
    logic [XW-1:0]   xb_reg;
    logic            big_pipe_reg [LOG_LAT+1];
    logic [FRAC_BITS-1:0] lb;
    logic [FRAC_BITS:0]   g;
    logic [40:0]     zprod;
    logic [ZW-1:0]   z_reg;
    logic [PW-1:0]   pq;
    logic [38:0]     cprod;
    logic [7:0]      code_reg;

    assign sgn = half_in[15];
    assign ex  = half_in[14:10];
    assign man = half_in[9:0];

    always_comb
    begin
        msb = '0;
        for (int b = 0; b < 10; b++)
        begin
            if (man[b])
            begin
                msb = 4'(b);
            end
        end
        sp_d   = SP_NONE;
        neg_d  = '0;
        frac_d = '0;
        if (ex == 5'h1F)
        begin
            sp_d = (man != '0 || sgn) ? SP_ZERO : SP_SAT;
        end
        else if (sgn)
        begin
            sp_d = SP_ZERO;
        end
        else if (ex == '0 && man == '0)
        begin
            sp_d = SP_ZERO;
        end
        else if (ex >= 5'd15)
        begin
            sp_d = SP_SAT;
        end
        else if (ex == '0)
        begin
            neg_d  = 5'd24 - {1'b0, msb};
            frac_d = 10'(man << (4'd10 - msb));
        end
        else
        begin
            neg_d  = 5'd15 - ex;
            frac_d = man;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_pipe_reg[0]  <= sp_d;
            neg_pipe_reg[0] <= neg_d;
            xa_reg          <= {1'b1, frac_d, 20'b0};
            for (int k = 1; k < CH_LAT - 1; k++)
            begin
                sp_pipe_reg[k] <= sp_pipe_reg[k-1];
            end
            for (int k = 1; k <= LOG_LAT; k++)
            begin
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
            end
        end
    end

    pqe_log2 u_log_a (
        .clk      (clk),
        .en       (en),
        .x_in     (xa_reg),
        .frac_out (la)
    );

    // -log2 L, then times m1
    assign t     = {neg_pipe_reg[LOG_LAT], 28'b0} - {5'b0, la};
    assign yprod = t * 12'd2610;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= yprod[44:14];
        end
    end

    pqe_exp2 u_exp_a (
        .clk   (clk),
        .en    (en),
        .z_in  ({4'b0, y_reg}),
        .p_out (lm)
    );

    assign nprod   = lm * 12'd2413;
    assign dprod   = lm * 12'd2392;
    assign num_sum = NUM_BASE + 36'(nprod[42:7]);

    assign den_sum = DEN_BASE + 36'(dprod[42:7]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_sum[34:2];
            den_reg <= den_sum[34:2];
        end
    end

    pqe_div u_div (
        .clk    (clk),
        .en     (en),
        .num_in (num_reg),
        .den_in (den_reg),
        .q_out  (r)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_pipe_reg[0] <= r[30];
            xb_reg          <= r[29] ? {r[29:0], 1'b0} : {1'b1, 30'b0};
            for (int k = 1; k <= LOG_LAT; k++)
            begin
                big_pipe_reg[k] <= big_pipe_reg[k-1];
            end
        end
    end

    pqe_log2 u_log_b (
        .clk      (clk),
        .en       (en),
        .x_in     (xb_reg),
        .frac_out (lb)
    );

    assign g     = big_pipe_reg[LOG_LAT] ? '0 : ({1'b1, 28'b0} - {1'b0, lb});
    assign zprod = g * 12'd2523;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg <= zprod[39:5];
        end
    end

    pqe_exp2 u_exp_b (
        .clk   (clk),
        .en    (en),
        .z_in  (z_reg),
        .p_out (pq)
    );

    assign cprod = pq * 8'd255;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (sp_pipe_reg[CH_LAT-2])
                SP_ZERO: code_reg <= 8'd0;
                SP_SAT:  code_reg <= 8'd255;
                default: code_reg <= cprod[37:30];
            endcase
        end
    end

    assign code = code_reg;

endmodule

FILE: rtl/pq_encode_half_rgb_to_8bit_top.sv
`timescale 1ns / 1ps
// channel | handshake             | payload
// --------+-----------------------+-----------------------------------------
// in      | in_valid / in_ready   | red_half, green_half, blue_half (fp16)
// out     | out_valid / out_ready | red_code, green_code, blue_code (8 bit)
//
// One pixel per clock while the output is not stalled.
// Each channel holds the four 28-step log/exp chains and the 31-step divider.
// Reset clears only the valid bits of the pipeline.
// A stall on out_ready freezes the whole pipeline; in_ready follows it.
module pq_encode_half_rgb_to_8bit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] red_half,
    input  logic [15:0] green_half,
    input  logic [15:0] blue_half,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_code,
    output logic [7:0]  green_code,
    output logic [7:0]  blue_code
);
    import pqe_pkg::*;

    logic adv;
    logic vld_reg [CH_LAT];

    assign adv      = !vld_reg[CH_LAT-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CH_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < CH_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[CH_LAT-1];

    pqe_channel u_red (
        .clk     (clk),
        .en      (adv),
        .half_in (red_half),
        .code    (red_code)
    );

    pqe_channel u_green (
        .clk     (clk),
        .en      (adv),
        .half_in (green_half),
        .code    (green_code)
    );

    pqe_channel u_blue (
        .clk     (clk),
        .en      (adv),
        .half_in (blue_half),
        .code    (blue_code)
    );

endmodule

FILE: rtl/pqe_checker.sv
`timescale 1ns / 1ps
module pqe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_code,
    input logic [7:0] green_code,
    input logic [7:0] blue_code
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({red_code, green_code, blue_code}))
        else $error("result changed while stalled");

    a_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    a_ready_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind pq_encode_half_rgb_to_8bit_top pqe_checker u_pqe_checker (.*);

FILE: sim/pq_encode_half_rgb_to_8bit_checker.sv
`timescale 1ns / 1ps
module pq_encode_half_rgb_to_8bit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] red_half,
    input  logic [15:0] green_half,
    input  logic [15:0] blue_half,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  red_code,
    input  logic [7:0]  green_code,
    input  logic [7:0]  blue_code,
    output int          failures,
    output int          queued,
    output int          pixels_seen
);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_codes_t;

    pixel_codes_t code_q[$];
    logic [63:0]  recip_root[1:28];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] step;
        lo = 0;
        for (int k = 31; k >= 0; k--)
        begin
            step = lo | (64'd1 << k);
            if (step * step <= v)
                lo = step;
        end
        return lo;
    endfunction

    initial
    begin
        logic [63:0] rt;
        rt = 64'd1 << 31;
        for (int i = 1; i <= 28; i++)
        begin
            rt = int_sqrt(rt << 30);
            recip_root[i] = (64'd1 << 60) / rt;
        end
    end

    // fractional log2 of x in [1,2) Q30, result Q28
    function automatic logic [63:0] log2_fraction(input logic [63:0] x);
        logic [63:0] acc;
        acc = 0;
        for (int i = 1; i <= 28; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                acc[28 - i] = 1'b1;
            end
        end
        return acc;
    endfunction

    // 2^-z, z in Q28, result Q30
    function automatic logic [63:0] pow2_neg(input logic [63:0] z);
        logic [63:0] p;
        logic [63:0] whole;
        p = 64'd1 << 30;
        whole = z >> 28;
        if (whole >= 62)
            return 0;
        for (int i = 1; i <= 28; i++)
        begin
            if (z[28 - i])
                p = (p * recip_root[i]) >> 30;
        end
        return p >> whole;
    endfunction

    function automatic logic [7:0] pq_code(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [63:0] nexp;
        logic [63:0] frac;
        logic [63:0] t;
        logic [63:0] lm;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] pq;
        int          msb;
        ex  = h[14:10];
        man = h[9:0];
        if (ex == 5'd31)
            return (man != 0 || h[15]) ? 8'd0 : 8'd255;
        if (h[15] || (ex == 0 && man == 0))
            return 8'd0;
        if (ex >= 5'd15)
            return 8'd255;
        if (ex == 0)
        begin
            msb = 0;
            for (int k = 0; k < 10; k++)
                if (man[k])
                    msb = k;
            nexp = 64'(24 - msb);
            frac = (64'(man) << (10 - msb)) & 64'd1023;
        end
        else
        begin
            nexp = 64'(15 - ex);
            frac = 64'(man);
        end
        t   = (nexp << 28) - log2_fraction((64'd1024 + frac) << 20);
        lm  = pow2_neg((t * 2610) >> 14);
        num = ((64'd3424 << 18) + ((64'd2413 * lm) >> 7)) >> 2;
        den = ((64'd1 << 30) + ((64'd2392 * lm) >> 7)) >> 2;
        r   = (num << 30) / den;
        if (r >= (64'd1 << 30))
            g = 0;
        else
        begin
            if (r < (64'd1 << 29))
                r = 64'd1 << 29;
            g = (64'd1 << 28) - log2_fraction(r << 1);
        end
        pq = pow2_neg((g * 2523) >> 5);
        return 8'((255 * pq) >> 30);
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s at %0t: got %0d expected %0d", what, $realtime, got, want);
        failures++;
    endtask

    initial
    begin
        failures    = 0;
        queued      = 0;
        pixels_seen = 0;
    end

    always @(posedge clk)
    begin
        pixel_codes_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (code_q.size() == 0)
                begin
                    report("unexpected result", red_code, -1);
                end
                else
                begin
                    e = code_q.pop_front();
                    if (red_code !== e.r)
                        report("red", red_code, e.r);
                    if (green_code !== e.g)
                        report("green", green_code, e.g);
                    if (blue_code !== e.b)
                        report("blue", blue_code, e.b);
                end
            end
            if (in_valid && in_ready)
            begin
                e.r = pq_code(red_half);
                e.g = pq_code(green_half);
                e.b = pq_code(blue_half);
                code_q.push_back(e);
                pixels_seen++;
            end
            queued = code_q.size();
        end
    end

endmodule

FILE: sim/pq_encode_half_rgb_to_8bit_top_tb.sv
`timescale 1ns / 1ps
module pq_encode_half_rgb_to_8bit_top_tb;

    import pqe_pkg::*;

    localparam int RANDOM_PIXELS = 650;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = CH_LAT + 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] red_half;
    logic [15:0] green_half;
    logic [15:0] blue_half;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  red_code;
    logic [7:0]  green_code;
    logic [7:0]  blue_code;
    int          failures;
    int          queued;
    int          pixels_seen;
    int          cycles;
    logic        started;
    logic        held_long;

    pq_encode_half_rgb_to_8bit_top DUT (.*);

    pq_encode_half_rgb_to_8bit_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("pq_encode_half_rgb_to_8bit_top verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // receiver: random stalls, and one long hold-off once traffic is flowing
    always
    begin
        int gap;
        @(negedge clk);
        if (started && !held_long && pixels_seen > 200)
        begin
            held_long = 1'b1;
            out_ready <= 1'b0;
            for (int k = 0; k < 400; k++)
                @(negedge clk);
            out_ready <= 1'b1;
        end
        else
        begin
            gap = pick_gap();
            if (gap == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        red_half   <= r;
        green_half <= g;
        blue_half  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic [15:0] rand_half();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return 16'($urandom);
        if (roll < 85)
            return {1'b0, 5'($urandom_range(1, 14)), 10'($urandom)};
        if (roll < 95)
            return {6'b0, 10'($urandom)};
        return {1'b0, 5'($urandom_range(15, 31)), 10'($urandom)};
    endfunction

    logic [15:0] corner [16] = '{
        16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFE01,
        16'h3C00, 16'h3BFF, 16'h0001, 16'h03FF, 16'h0400, 16'h7BFF,
        16'h3800, 16'h1234, 16'hFFFF, 16'h8001
    };

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        red_half   = '0;
        green_half = '0;
        blue_half  = '0;
        cycles     = 0;
        started    = 1'b0;
        held_long  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n   = 1'b1;
        started = 1'b1;
        for (int i = 0; i < 16; i++)
            send_pixel(corner[i], corner[(i + 5) % 16], corner[(i + 11) % 16]);
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i == 450)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (queued != 0)
                    @(negedge clk);
            end
            send_pixel(rand_half(), rand_half(), rand_half());
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (queued != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d pixels: fp16 corners, subnormals, NaN/inf, saturation",
                 pixels_seen);
        $display("with random stalls, a long output hold-off and a full drain pause");
        if (failures == 0 && queued == 0)
            $display("pq_encode_half_rgb_to_8bit_top verification clean");
        else
            $display("pq_encode_half_rgb_to_8bit_top verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pqe_pkg.sv
rtl/pqe_log2.sv
rtl/pqe_exp2.sv
rtl/pqe_div.sv
rtl/pqe_channel.sv
rtl/pq_encode_half_rgb_to_8bit_top.sv
rtl/pqe_checker.sv
sim/pq_encode_half_rgb_to_8bit_checker.sv
sim/pq_encode_half_rgb_to_8bit_top_tb.sv
